FILE: design/srd_pkg.sv
package srd_pkg;

  // Default sizes of the block; the top level hands them down as parameters.
  localparam int BUFFER_DEPTH_DEF = 262144;
  localparam int MAX_WINDOW_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF  = 24;

  // Configuration register widths and port shape.
  localparam int WLEN_W     = 17;
  localparam int GAIN_W     = 16;
  localparam int CFG_W      = 17;
  localparam int CFG_ADDR_W = 2;

  // Unity gain in unsigned Q1.15.
  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;

  // Register reset values.
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd16384;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_LEN    = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_WET_GAIN      = 2'd2
  } reg_idx_t;

  // Per-item control decided at acceptance and carried into the mixing stage.
  typedef struct packed {
    logic active;    // item reads a reversed sample
    logic self_hit;  // reversed read hits the entry this same item writes
  } ctrl_flags_t;

endpackage

FILE: design/srd_store.sv
module srd_store #(
  parameter int DEPTH  = srd_pkg::BUFFER_DEPTH_DEF,
  parameter int ADDR_W = $clog2(srd_pkg::BUFFER_DEPTH_DEF),
  parameter int DATA_W = 2 * srd_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  // Simple dual-port sample memory; a read during a write to the same
  // entry returns the old contents.
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/srd_ctrl.sv
module srd_ctrl #(
  parameter int BUFFER_DEPTH = srd_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_WINDOW   = srd_pkg::MAX_WINDOW_DEF,
  parameter int ADDR_W       = $clog2(srd_pkg::BUFFER_DEPTH_DEF),
  parameter int CNT_W        = $clog2(srd_pkg::MAX_WINDOW_DEF + 2)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [srd_pkg::WLEN_W-1:0]  window_len,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [ADDR_W-1:0]           rd_addr,
  output srd_pkg::ctrl_flags_t        flags
);

  localparam int EXT_W = (CNT_W > srd_pkg::WLEN_W) ? CNT_W : srd_pkg::WLEN_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);
  localparam logic [EXT_W-1:0]  MAX_EXT   = EXT_W'(MAX_WINDOW);

  logic [ADDR_W-1:0] write_pos;
  logic [ADDR_W-1:0] read_pos;
  logic [CNT_W-1:0]  window_count;
  logic [CNT_W-1:0]  reads_left;
  logic              window_active;

  logic [EXT_W-1:0]  len_ext;
  logic [CNT_W-1:0]  win;
  logic              start;
  logic              active_eff;
  logic [ADDR_W-1:0] rp_eff;
  logic [CNT_W-1:0]  reads_eff;
  logic [CNT_W-1:0]  reads_next;
  logic [CNT_W-1:0]  count_inc;

  always_comb begin
    len_ext = EXT_W'(window_len);
    if (len_ext == '0) begin
      len_ext = EXT_W'(1);
    end else if (len_ext > MAX_EXT) begin
      len_ext = MAX_EXT;
    end
    win = len_ext[CNT_W-1:0];

    // A new window opens at the current write position once the count
    // reaches the window length.
    start      = (window_count >= win);
    active_eff = start | window_active;
    rp_eff     = start ? write_pos : read_pos;
    reads_eff  = start ? win : reads_left;
    reads_next = (reads_eff == '0) ? '0 : reads_eff - CNT_W'(1);
    count_inc  = window_count + CNT_W'(1);
  end

  assign wr_addr        = write_pos;
  assign rd_addr        = rp_eff;
  assign flags.active   = active_eff;
  assign flags.self_hit = active_eff && (rp_eff == write_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= '0;
      read_pos      <= '0;
      window_count  <= '0;
      reads_left    <= '0;
      window_active <= 1'b0;
    end else if (accept) begin
      write_pos    <= (write_pos == LAST_ADDR) ? '0 : write_pos + ADDR_W'(1);
      window_count <= (count_inc > win) ? '0 : count_inc;
      if (active_eff) begin
        read_pos      <= (rp_eff == '0) ? LAST_ADDR : rp_eff - ADDR_W'(1);
        reads_left    <= reads_next;
        window_active <= (reads_next != '0);
      end
    end
  end

endmodule

FILE: design/srd_mix.sv
module srd_mix #(
  parameter int SAMPLE_BITS = srd_pkg::SAMPLE_BITS_DEF,
  parameter int ADDR_W      = $clog2(srd_pkg::BUFFER_DEPTH_DEF)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [SAMPLE_BITS-1:0]       left_in,
  input  logic [SAMPLE_BITS-1:0]       right_in,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [ADDR_W-1:0]            rd_addr,
  input  srd_pkg::ctrl_flags_t         flags,
  input  logic [2*SAMPLE_BITS-1:0]     rd_data,
  input  logic [srd_pkg::GAIN_W-1:0]   fb_gain,
  input  logic [srd_pkg::GAIN_W-1:0]   wet_gain,
  input  logic [srd_pkg::GAIN_W-1:0]   dry_gain,
  input  logic                         out_ready,
  output logic                         in_ready,
  output logic                         out_valid,
  output logic [SAMPLE_BITS-1:0]       left_out,
  output logic [SAMPLE_BITS-1:0]       right_out,
  output logic                         we,
  output logic [ADDR_W-1:0]            waddr,
  output logic [2*SAMPLE_BITS-1:0]     wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [SB+16:0] ROUND_HALF = (SB+17)'(16384);
  localparam logic signed [SB+1:0]  SAT_MAX    = {3'b000, {(SB-1){1'b1}}};
  localparam logic signed [SB+1:0]  SAT_MIN    = {3'b111, {(SB-1){1'b0}}};

  // Q1.15 product rounded to nearest, ties toward plus infinity.
  function automatic logic signed [SB:0] mul_q15(input logic signed [SB-1:0] x,
                                                 input logic [srd_pkg::GAIN_W-1:0] g);
    logic signed [SB+16:0] prod;
    prod = x * $signed({1'b0, g});
    prod = prod + ROUND_HALF;
    return $signed(prod[SB+15:15]);
  endfunction

  function automatic logic [SB-1:0] sat(input logic signed [SB+1:0] v);
    logic [SB-1:0] res;
    if (v > SAT_MAX) begin
      res = SAT_MAX[SB-1:0];
    end else if (v < SAT_MIN) begin
      res = SAT_MIN[SB-1:0];
    end else begin
      res = v[SB-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [SB+1:0] ext(input logic signed [SB:0] v);
    return $signed({v[SB], v});
  endfunction

  // Mixing stage registers.
  logic              s1_valid;
  logic [SB-1:0]     s1_l;
  logic [SB-1:0]     s1_r;
  logic [ADDR_W-1:0] s1_wp;
  logic              s1_active;
  logic              s1_self;
  logic              s1_prev;
  logic              s1_phase;
  logic [SB-1:0]     fb_l;
  logic [SB-1:0]     fb_r;
  logic [SB-1:0]     last_l;
  logic [SB-1:0]     last_r;

  logic [SB-1:0] wl_l, wl_r;
  logic [SB-1:0] rl_l, rl_r;
  logic [SB-1:0] fb_l_next, fb_r_next;
  logic [SB-1:0] mix_l, mix_r;
  logic          use_last;
  logic          step_ready;
  logic          s1_done;

  always_comb begin
    wl_l = sat(ext(mul_q15(fb_l, fb_gain)) + $signed({{2{s1_l[SB-1]}}, s1_l}));
    wl_r = sat(ext(mul_q15(fb_r, fb_gain)) + $signed({{2{s1_r[SB-1]}}, s1_r}));

    // The reversed sample comes from the memory unless it was written by this
    // item or by the item just before, which the memory cannot return yet.
    use_last = s1_self | s1_prev;
    rl_l = use_last ? last_l : rd_data[SB-1:0];
    rl_r = use_last ? last_r : rd_data[2*SB-1:SB];

    fb_l_next = sat(ext(mul_q15(rl_l, fb_gain)));
    fb_r_next = sat(ext(mul_q15(rl_r, fb_gain)));
    mix_l = sat(ext(mul_q15(s1_l, dry_gain)) + ext(mul_q15(rl_l, wet_gain)));
    mix_r = sat(ext(mul_q15(s1_r, dry_gain)) + ext(mul_q15(rl_r, wet_gain)));
  end

  // A self-hit item first forms its store value in the mixing stage, which it
  // then reads back as its reversed sample.
  assign step_ready = s1_valid && (!s1_self || s1_phase);
  assign s1_done    = step_ready && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_done;

  assign we    = s1_done;
  assign waddr = s1_wp;
  assign wdata = {wl_r, wl_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_phase  <= 1'b0;
      out_valid <= 1'b0;
      fb_l      <= '0;
      fb_r      <= '0;
    end else begin
      if (accept) begin
        s1_valid  <= 1'b1;
        s1_phase  <= 1'b0;
        s1_l      <= left_in;
        s1_r      <= right_in;
        s1_wp     <= wr_addr;
        s1_active <= flags.active;
        s1_self   <= flags.self_hit;
        s1_prev   <= flags.active && s1_valid && (rd_addr == s1_wp);
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (s1_valid && s1_self && !s1_phase) begin
        s1_phase <= 1'b1;
        last_l   <= wl_l;
        last_r   <= wl_r;
      end

      if (s1_done) begin
        last_l    <= wl_l;
        last_r    <= wl_r;
        out_valid <= 1'b1;
        if (s1_active) begin
          fb_l      <= fb_l_next;
          fb_r      <= fb_r_next;
          left_out  <= mix_l;
          right_out <= mix_r;
        end else begin
          left_out  <= wl_l;
          right_out <= wl_r;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/stereo_reverse_delay_core.sv
// A result is registered in the mixing stage and then in the output register,
// and an item whose reverse read of a newly opened window lands on the entry
// that it writes first forms its store value there. Throughput: one item per
// cycle, set by the single write and single read port of the sample memory,
// while m_tready keeps up; such a window-start item holds off the next one.
// Reset (rst, synchronous, active high) clears the pointers, window counters,
// feedback and handshake state and restores the register defaults; the
// sample memory is not cleared and no clearing pass runs.
module stereo_reverse_delay_core #(
  parameter int BUFFER_DEPTH = srd_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_WINDOW   = srd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS  = srd_pkg::SAMPLE_BITS_DEF,
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream: s_tdata holds left_in, then right_in, zero padded.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [TDATA_W-1:0]             s_tdata,
  // Output stream: m_tdata holds left_out, then right_out, zero padded.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [TDATA_W-1:0]             m_tdata,
  // Register writes: window_len, feedback_gain, wet_gain at indexes 0 to 2.
  input  logic                           cfg_we,
  input  logic [srd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [srd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
  localparam int DATA_W = 2 * SAMPLE_BITS;

  // Configuration registers, held raw; clamping happens on use.
  logic [srd_pkg::WLEN_W-1:0] window_len;
  logic [srd_pkg::GAIN_W-1:0] feedback_gain;
  logic [srd_pkg::GAIN_W-1:0] wet_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= srd_pkg::WINDOW_LEN_RST;
      feedback_gain <= srd_pkg::GAIN_RST;
      wet_gain      <= srd_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        srd_pkg::REG_WINDOW_LEN: begin
          window_len <= cfg_data;
        end
        srd_pkg::REG_FEEDBACK_GAIN: begin
          feedback_gain <= cfg_data[srd_pkg::GAIN_W-1:0];
        end
        srd_pkg::REG_WET_GAIN: begin
          wet_gain <= cfg_data[srd_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Gains above unity are treated as unity; the dry gain is the complement.
  logic [srd_pkg::GAIN_W-1:0] fb_gain;
  logic [srd_pkg::GAIN_W-1:0] wet_eff;
  logic [srd_pkg::GAIN_W-1:0] dry_gain;

  assign fb_gain  = (feedback_gain > srd_pkg::GAIN_ONE) ? srd_pkg::GAIN_ONE : feedback_gain;
  assign wet_eff  = (wet_gain > srd_pkg::GAIN_ONE) ? srd_pkg::GAIN_ONE : wet_gain;
  assign dry_gain = srd_pkg::GAIN_ONE - wet_eff;

  logic                 accept;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  srd_pkg::ctrl_flags_t flags;
  logic [DATA_W-1:0]    rd_data;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [DATA_W-1:0]    mem_wdata;
  logic [SAMPLE_BITS-1:0] left_out;
  logic [SAMPLE_BITS-1:0] right_out;

  assign accept = s_tvalid && s_tready;

  // Window and pointer bookkeeping: decides, for each accepted item, where
  // it writes, where its reversed sample is read and whether a window is open.
  srd_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_WINDOW   (MAX_WINDOW),
    .ADDR_W       (ADDR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .window_len (window_len),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .flags      (flags)
  );

  // Stereo sample memory: the reversed read is launched when the item is
  // accepted; the item's own store value is written from the mixing stage.
  srd_store #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Feedback, wet/dry mixing and the output register. Reads that the memory
  // cannot answer yet are served from the last store value formed here.
  srd_mix #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ADDR_W      (ADDR_W)
  ) u_mix (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .left_in   (s_tdata[SAMPLE_BITS-1:0]),
    .right_in  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .flags     (flags),
    .rd_data   (rd_data),
    .fb_gain   (fb_gain),
    .wet_gain  (wet_eff),
    .dry_gain  (dry_gain),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .left_out  (left_out),
    .right_out (right_out),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata)
  );

  assign m_tdata = TDATA_W'({right_out, left_out});

endmodule
